// File: hdl/tiqt_pkg.sv
`timescale 1ns / 1ps

package tiqt_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int CMD_DEPTH      = 2;

    // input modes
    localparam logic [1:0] MODE_PUSH_RAW = 2'd0;
    localparam logic [1:0] MODE_PUSH_REC = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;

    // internal command opcodes
    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // control codes
    localparam logic [4:0] CTRL_NONE        = 5'd0;
    localparam logic [4:0] CTRL_LINEEND     = 5'd1;
    localparam logic [4:0] CTRL_BACKSPACE   = 5'd2;
    localparam logic [4:0] CTRL_DELETE      = 5'd3;
    localparam logic [4:0] CTRL_EOF         = 5'd4;
    localparam logic [4:0] CTRL_INTERRUPT   = 5'd5;
    localparam logic [4:0] CTRL_NAV_FIRST   = 5'd6;
    localparam logic [4:0] CTRL_NAV_LAST    = 5'd14;
    localparam logic [4:0] CTRL_SCROLL_UP   = 5'd15;
    localparam logic [4:0] CTRL_SCROLL_DOWN = 5'd16;
    localparam logic [4:0] CTRL_UNSUPPORTED = 5'd17;

    // read status
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_CHAR = 2'd1;
    localparam logic [1:0] RD_EOF  = 2'd2;

    // configuration register indexes
    localparam logic CFG_RAW_MODE   = 1'b0;
    localparam logic CFG_FOREGROUND = 1'b1;

    // character bytes
    localparam logic [7:0] CHAR_ETX   = 8'h03;
    localparam logic [7:0] CHAR_EOT   = 8'h04;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_ESC   = 8'h1b;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;

    localparam logic [3:0] NAV_LONG_FIRST = 4'd6;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [4:0] code;
    } rec_t;

    typedef struct packed {
        logic [1:0] op;
        rec_t       rec;
    } cmd_t;

    typedef struct packed {
        logic       en;
        logic       index;
        logic       data;
    } cfg_wr_t;

    typedef struct packed {
        logic        push_accepted;
        logic [1:0]  read_status;
        logic [7:0]  out_char;
        logic        interrupt_request;
        logic        scroll_up_request;
        logic        scroll_down_request;
        logic [31:0] drop_count;
    } result_t;

    function automatic logic [4:0] classify_byte(input logic [7:0] b);
        logic [4:0] c;
        if (b inside {CHAR_LF, CHAR_CR})
            c = CTRL_LINEEND;
        else if (b == CHAR_BS)
            c = CTRL_BACKSPACE;
        else if (b == CHAR_DEL)
            c = CTRL_DELETE;
        else if (b == CHAR_EOT)
            c = CTRL_EOF;
        else if (b == CHAR_ETX)
            c = CTRL_INTERRUPT;
        else if (b == CHAR_TAB)
            c = CTRL_NONE;
        else if (b < CHAR_SPACE)
            c = CTRL_UNSUPPORTED;
        else
            c = CTRL_NONE;
        return c;
    endfunction

    function automatic logic [2:0] nav_len(input logic [3:0] idx);
        return (idx >= NAV_LONG_FIRST) ? 3'd4 : 3'd3;
    endfunction

    // byte at position pos of the escape sequence for navigation index idx
    function automatic logic [7:0] nav_byte(input logic [3:0] idx, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0: b = CHAR_ESC;
            2'd1: b = "[";
            2'd2:
            begin
                case (idx)
                    4'd0:    b = "A";
                    4'd1:    b = "B";
                    4'd2:    b = "C";
                    4'd3:    b = "D";
                    4'd4:    b = "H";
                    4'd5:    b = "F";
                    4'd6:    b = "3";
                    4'd7:    b = "5";
                    4'd8:    b = "6";
                    default: b = 8'h00;
                endcase
            end
            default: b = (idx >= NAV_LONG_FIRST) ? "~" : 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/tiqt_front.sv
`timescale 1ns / 1ps

module tiqt_front
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic              is_control,
    input  logic [7:0]        data_byte,
    input  logic [4:0]        control_code,
    input  logic              q_full,
    output logic              q_push,
    output tiqt_pkg::cmd_t    q_cmd
);

    logic [4:0] raw_code;

    assign raw_code = tiqt_pkg::classify_byte(data_byte);
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.rec.ch = data_byte;
        case (mode)
            tiqt_pkg::MODE_PUSH_RAW:
            begin
                q_cmd.op       = tiqt_pkg::OP_PUSH;
                q_cmd.rec.kind = (raw_code != tiqt_pkg::CTRL_NONE);
                q_cmd.rec.code = raw_code;
            end
            tiqt_pkg::MODE_PUSH_REC:
            begin
                q_cmd.op       = tiqt_pkg::OP_PUSH;
                q_cmd.rec.kind = is_control;
                q_cmd.rec.code = control_code;
            end
            tiqt_pkg::MODE_READ:
            begin
                q_cmd.op       = tiqt_pkg::OP_READ;
                q_cmd.rec.kind = 1'b0;
                q_cmd.rec.code = control_code;
            end
            default:
            begin
                q_cmd.op       = tiqt_pkg::OP_NOP;
                q_cmd.rec.kind = 1'b0;
                q_cmd.rec.code = control_code;
            end
        endcase
    end

endmodule

// File: hdl/tiqt_cmd_fifo.sv
`timescale 1ns / 1ps

module tiqt_cmd_fifo
#(
    parameter int DEPTH = tiqt_pkg::CMD_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tiqt_pkg::cmd_t    push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output tiqt_pkg::cmd_t    pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tiqt_pkg::cmd_t entries_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hdl/tiqt_back.sv
`timescale 1ns / 1ps

module tiqt_back
#(
    parameter int RING_DEPTH = tiqt_pkg::RING_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tiqt_pkg::cfg_wr_t    cfg,
    input  logic                 cmd_valid,
    input  tiqt_pkg::cmd_t       cmd,
    output logic                 cmd_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tiqt_pkg::result_t    res
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    tiqt_pkg::rec_t    ring_mem [RING_DEPTH];
    tiqt_pkg::rec_t    rd_data_reg;
    tiqt_pkg::rec_t    rec;
    tiqt_pkg::result_t res_reg, res_next;

    logic              state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next, wp_inc;
    logic [PTR_W-1:0]  rp_reg, rp_next, rp_inc;
    logic [PTR_W-1:0]  rd_addr;
    logic [31:0]       drop_reg, drop_next;
    logic [3:0]        seq_idx_reg, seq_idx_next;
    logic [2:0]        seq_len_reg, seq_len_next;
    logic [1:0]        seq_pos_reg, seq_pos_next;
    logic              sup_reg, sup_next;
    logic              sdn_reg, sdn_next;
    logic              raw_reg, raw_next;
    logic              fg_reg, fg_next;
    logic              res_valid_reg, res_valid_next;
    logic              out_free, res_load, mem_we, rd_en;
    logic              is_skip, nav_hit, up_hit, dn_hit;
    logic [3:0]        nav_idx;
    logic [4:0]        nav_off;

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rec       = rd_data_reg;
    assign wp_inc    = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign nav_off   = rec.code - tiqt_pkg::CTRL_NAV_FIRST;
    assign nav_idx   = nav_off[3:0];

    // classify the fetched record
    always_comb
    begin
        is_skip  = 1'b0;
        nav_hit  = 1'b0;
        up_hit   = 1'b0;
        dn_hit   = 1'b0;
        if (rec.kind && rec.code != tiqt_pkg::CTRL_NONE)
        begin
            case (rec.code)
                tiqt_pkg::CTRL_LINEEND, tiqt_pkg::CTRL_BACKSPACE, tiqt_pkg::CTRL_DELETE,
                tiqt_pkg::CTRL_EOF, tiqt_pkg::CTRL_INTERRUPT:
                    is_skip = 1'b0;
                tiqt_pkg::CTRL_SCROLL_UP:
                begin
                    is_skip = 1'b1;
                    up_hit  = !raw_reg;
                end
                tiqt_pkg::CTRL_SCROLL_DOWN:
                begin
                    is_skip = 1'b1;
                    dn_hit  = !raw_reg;
                end
                default:
                begin
                    if (rec.code inside {[tiqt_pkg::CTRL_NAV_FIRST:tiqt_pkg::CTRL_NAV_LAST]})
                        nav_hit = 1'b1;
                    else
                        is_skip = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        drop_next    = drop_reg;
        seq_idx_next = seq_idx_reg;
        seq_len_next = seq_len_reg;
        seq_pos_next = seq_pos_reg;
        sup_next     = sup_reg;
        sdn_next     = sdn_reg;
        raw_next     = raw_reg;
        fg_next      = fg_reg;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = rp_reg;
        cmd_pop      = 1'b0;
        res_load     = 1'b0;
        res_next     = '0;

        if (state_reg == ST_IDLE)
        begin
            if (cmd_valid && out_free)
            begin
                cmd_pop = 1'b1;
                case (cmd.op)
                    tiqt_pkg::OP_PUSH:
                    begin
                        res_load = 1'b1;
                        if (wp_inc == rp_reg)
                            drop_next = drop_reg + 32'd1;
                        else
                        begin
                            mem_we                 = 1'b1;
                            wp_next                = wp_inc;
                            res_next.push_accepted = 1'b1;
                        end
                    end
                    tiqt_pkg::OP_READ:
                    begin
                        if ({1'b0, seq_pos_reg} < seq_len_reg)
                        begin
                            // serve the pending escape sequence first
                            res_load             = 1'b1;
                            res_next.read_status = tiqt_pkg::RD_CHAR;
                            res_next.out_char    = tiqt_pkg::nav_byte(seq_idx_reg, seq_pos_reg);
                            if ({1'b0, seq_pos_reg} + 3'd1 >= seq_len_reg)
                            begin
                                seq_pos_next = '0;
                                seq_len_next = '0;
                            end
                            else
                                seq_pos_next = seq_pos_reg + 2'd1;
                        end
                        else if (rp_reg == wp_reg)
                            res_load = 1'b1;
                        else
                        begin
                            rd_en      = 1'b1;
                            sup_next   = 1'b0;
                            sdn_next   = 1'b0;
                            state_next = ST_EVAL;
                        end
                    end
                    default:
                        res_load = 1'b1;
                endcase
            end
        end
        else
        begin
            rd_addr                      = rp_inc;
            res_next.read_status         = tiqt_pkg::RD_CHAR;
            res_next.scroll_up_request   = sup_reg | up_hit;
            res_next.scroll_down_request = sdn_reg | dn_hit;
            if (!rec.kind || rec.code == tiqt_pkg::CTRL_NONE)
                res_next.out_char = rec.ch;
            else
            begin
                case (rec.code)
                    tiqt_pkg::CTRL_LINEEND:   res_next.out_char = tiqt_pkg::CHAR_LF;
                    tiqt_pkg::CTRL_BACKSPACE: res_next.out_char = tiqt_pkg::CHAR_BS;
                    tiqt_pkg::CTRL_DELETE:    res_next.out_char = tiqt_pkg::CHAR_DEL;
                    tiqt_pkg::CTRL_EOF:
                    begin
                        if (raw_reg)
                            res_next.out_char = tiqt_pkg::CHAR_EOT;
                        else
                            res_next.read_status = tiqt_pkg::RD_EOF;
                    end
                    tiqt_pkg::CTRL_INTERRUPT:
                    begin
                        res_next.out_char          = tiqt_pkg::CHAR_ETX;
                        res_next.interrupt_request = !raw_reg && fg_reg;
                    end
                    default:
                    begin
                        if (nav_hit)
                            res_next.out_char = tiqt_pkg::CHAR_ESC;
                        else
                            res_next.read_status = tiqt_pkg::RD_NONE;
                    end
                endcase
            end

            if (is_skip)
            begin
                if (rp_inc != wp_reg)
                begin
                    // drop this record and fetch the next one
                    rp_next  = rp_inc;
                    rd_en    = 1'b1;
                    sup_next = sup_reg | up_hit;
                    sdn_next = sdn_reg | dn_hit;
                end
                else if (out_free)
                begin
                    rp_next    = rp_inc;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            else if (out_free)
            begin
                rp_next    = rp_inc;
                res_load   = 1'b1;
                state_next = ST_IDLE;
                if (nav_hit)
                begin
                    seq_idx_next = nav_idx;
                    seq_len_next = tiqt_pkg::nav_len(nav_idx);
                    seq_pos_next = 2'd1;
                end
            end
        end

        res_next.drop_count = drop_next;

        if (cfg.en)
        begin
            case (cfg.index)
                tiqt_pkg::CFG_RAW_MODE:
                begin
                    raw_next     = cfg.data;
                    seq_len_next = '0;
                    seq_pos_next = '0;
                    seq_idx_next = '0;
                end
                default: fg_next = cfg.data;
            endcase
        end

        if (res_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            drop_reg      <= '0;
            seq_idx_reg   <= '0;
            seq_len_reg   <= '0;
            seq_pos_reg   <= '0;
            sup_reg       <= 1'b0;
            sdn_reg       <= 1'b0;
            raw_reg       <= 1'b0;
            fg_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            drop_reg      <= drop_next;
            seq_idx_reg   <= seq_idx_next;
            seq_len_reg   <= seq_len_next;
            seq_pos_reg   <= seq_pos_next;
            sup_reg       <= sup_next;
            sdn_reg       <= sdn_next;
            raw_reg       <= raw_next;
            fg_reg        <= fg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wp_reg] <= cmd.rec;
        if (rd_en)
            rd_data_reg <= ring_mem[rd_addr];
    end

    a_eval_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> rp_reg != wp_reg)
        else $error("record fetch on empty ring");

    a_no_push_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |=> $stable(wp_reg))
        else $error("write pointer moved during a read");

    a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg != $past(drop_reg) |-> drop_reg == $past(drop_reg) + 32'd1)
        else $error("drop counter jumped");

    a_seq_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg != 3'd0 |-> ({1'b0, seq_pos_reg} < seq_len_reg
            && (seq_len_reg == 3'd3 || seq_len_reg == 3'd4)))
        else $error("escape sequence position out of range");

endmodule

// File: hdl/terminal_input_queue_translator.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_ready     mode, is_control, data_byte, control_code
// out       out_valid / out_ready   push_accepted, read_status, out_char,
//                                   interrupt_request, scroll_up_request,
//                                   scroll_down_request, drop_count
// cfg       cfg_write               cfg_index, cfg_data
//
// Push, no-op and pending escape bytes are handled in the idle state without a ring fetch.
// A read that fetches from the ring passes through the evaluate state, which examines each fetched record in turn;
// the single-port ring memory with its registered read sets this.
// A two-entry command queue separates input acceptance from execution.
// Reset clears pointers, counters and config; ring contents are not cleared.
// A stalled out channel holds the back end; the queue keeps taking items until full.

module terminal_input_queue_translator
#(
    parameter int RING_DEPTH = tiqt_pkg::RING_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic        is_control,
    input  logic [7:0]  data_byte,
    input  logic [4:0]  control_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        push_accepted,
    output logic [1:0]  read_status,
    output logic [7:0]  out_char,
    output logic        interrupt_request,
    output logic        scroll_up_request,
    output logic        scroll_down_request,
    output logic [31:0] drop_count
);

    tiqt_pkg::cmd_t    q_in_cmd, q_out_cmd;
    tiqt_pkg::cfg_wr_t cfg;
    tiqt_pkg::result_t res;
    logic              q_push, q_full, q_empty, q_pop;

    assign cfg.en    = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    tiqt_front u_front
    (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .is_control   (is_control),
        .data_byte    (data_byte),
        .control_code (control_code),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_in_cmd)
    );

    tiqt_cmd_fifo #(.DEPTH(tiqt_pkg::CMD_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out_cmd)
    );

    tiqt_back #(.RING_DEPTH(RING_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (!q_empty),
        .cmd       (q_out_cmd),
        .cmd_pop   (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign push_accepted       = res.push_accepted;
    assign read_status         = res.read_status;
    assign out_char            = res.out_char;
    assign interrupt_request   = res.interrupt_request;
    assign scroll_up_request   = res.scroll_up_request;
    assign scroll_down_request = res.scroll_down_request;
    assign drop_count          = res.drop_count;

endmodule

// File: bench/terminal_input_queue_translator_tb.sv
`timescale 1ns / 1ps

module terminal_input_queue_translator_tb;

    localparam int DEPTH        = tiqt_pkg::RING_DEPTH_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int QUIET_CYCLES = 12;
    localparam int LONG_STALL   = 400;

    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam logic [7:0] NAV_FINAL [9] = '{"A", "B", "C", "D", "H", "F", "3", "5", "6"};
    localparam logic [7:0] DIRECTED_BYTES [7] =
        '{tiqt_pkg::CHAR_ETX, tiqt_pkg::CHAR_EOT, tiqt_pkg::CHAR_CR, tiqt_pkg::CHAR_BS,
          tiqt_pkg::CHAR_DEL, tiqt_pkg::CHAR_TAB, 8'hff};

    typedef struct packed {
        logic [1:0] mode;
        logic       is_control;
        logic [7:0] data_byte;
        logic [4:0] control_code;
    } key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = '0;
    logic        is_control = 1'b0;
    logic [7:0]  data_byte = '0;
    logic [4:0]  control_code = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        push_accepted;
    logic [1:0]  read_status;
    logic [7:0]  out_char;
    logic        interrupt_request;
    logic        scroll_up_request;
    logic        scroll_down_request;
    logic [31:0] drop_count;

    // shadow of the translator state
    logic                raw_mode_q = 1'b0;
    logic                fg_present_q = 1'b0;
    tiqt_pkg::rec_t      ring_img [DEPTH];
    logic [PTR_W-1:0]    wr_ptr = '0;
    logic [PTR_W-1:0]    rd_ptr = '0;
    logic [31:0]         drops = '0;
    logic [7:0]          esc_bytes [4] = '{default: 8'h00};
    logic [2:0]          esc_len = '0;
    logic [2:0]          esc_pos = '0;

    key_t                key_queue [$];
    tiqt_pkg::result_t   expected_replies [$];
    key_t                held_key;
    tiqt_pkg::result_t   want_reply;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          sender_paused = 1'b0;
    int          stall_request = 0;
    int          stall_left = 0;
    int          queued_keys = 0;
    int          keys_sent = 0;
    int          results_seen = 0;
    int          eof_reads = 0;
    int          escape_bytes = 0;
    int          failures = 0;
    int          cycle_count = 0;

    terminal_input_queue_translator u_top
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .mode                (mode),
        .is_control          (is_control),
        .data_byte           (data_byte),
        .control_code        (control_code),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .push_accepted       (push_accepted),
        .read_status         (read_status),
        .out_char            (out_char),
        .interrupt_request   (interrupt_request),
        .scroll_up_request   (scroll_up_request),
        .scroll_down_request (scroll_down_request),
        .drop_count          (drop_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] next_escape_byte();
        logic [7:0] b;
        b = esc_bytes[esc_pos[1:0]];
        esc_pos++;
        if (esc_pos >= esc_len)
        begin
            esc_pos = '0;
            esc_len = '0;
        end
        escape_bytes++;
        return b;
    endfunction

    function automatic void translate_key(input key_t k);
        tiqt_pkg::result_t r;
        tiqt_pkg::rec_t    rec;
        logic              done;
        logic [3:0]        nav;
        r = '0;
        rec = '0;
        if (k.mode == tiqt_pkg::MODE_PUSH_RAW || k.mode == tiqt_pkg::MODE_PUSH_REC)
        begin
            rec.ch = k.data_byte;
            if (k.mode == tiqt_pkg::MODE_PUSH_REC)
            begin
                rec.kind = k.is_control;
                rec.code = k.control_code;
            end
            else
            begin
                if (k.data_byte == tiqt_pkg::CHAR_LF || k.data_byte == tiqt_pkg::CHAR_CR)
                    rec.code = tiqt_pkg::CTRL_LINEEND;
                else if (k.data_byte == tiqt_pkg::CHAR_BS)
                    rec.code = tiqt_pkg::CTRL_BACKSPACE;
                else if (k.data_byte == tiqt_pkg::CHAR_DEL)
                    rec.code = tiqt_pkg::CTRL_DELETE;
                else if (k.data_byte == tiqt_pkg::CHAR_EOT)
                    rec.code = tiqt_pkg::CTRL_EOF;
                else if (k.data_byte == tiqt_pkg::CHAR_ETX)
                    rec.code = tiqt_pkg::CTRL_INTERRUPT;
                else if (k.data_byte < tiqt_pkg::CHAR_SPACE &&
                         k.data_byte != tiqt_pkg::CHAR_TAB)
                    rec.code = tiqt_pkg::CTRL_UNSUPPORTED;
                else
                    rec.code = tiqt_pkg::CTRL_NONE;
                rec.kind = (rec.code != tiqt_pkg::CTRL_NONE);
            end
            // keep one slot free: a full ring drops the push
            if (ptr_next(wr_ptr) == rd_ptr)
                drops++;
            else
            begin
                ring_img[wr_ptr] = rec;
                wr_ptr = ptr_next(wr_ptr);
                r.push_accepted = 1'b1;
            end
        end
        else if (k.mode == tiqt_pkg::MODE_READ)
        begin
            if (esc_pos < esc_len)
            begin
                r.read_status = tiqt_pkg::RD_CHAR;
                r.out_char = next_escape_byte();
            end
            else
            begin
                done = 1'b0;
                while (!done && rd_ptr != wr_ptr)
                begin
                    rec = ring_img[rd_ptr];
                    rd_ptr = ptr_next(rd_ptr);
                    done = 1'b1;
                    r.read_status = tiqt_pkg::RD_CHAR;
                    if (!rec.kind || rec.code == tiqt_pkg::CTRL_NONE)
                        r.out_char = rec.ch;
                    else if (rec.code == tiqt_pkg::CTRL_LINEEND)
                        r.out_char = tiqt_pkg::CHAR_LF;
                    else if (rec.code == tiqt_pkg::CTRL_BACKSPACE)
                        r.out_char = tiqt_pkg::CHAR_BS;
                    else if (rec.code == tiqt_pkg::CTRL_DELETE)
                        r.out_char = tiqt_pkg::CHAR_DEL;
                    else if (rec.code == tiqt_pkg::CTRL_EOF)
                    begin
                        if (raw_mode_q)
                            r.out_char = tiqt_pkg::CHAR_EOT;
                        else
                        begin
                            r.read_status = tiqt_pkg::RD_EOF;
                            eof_reads++;
                        end
                    end
                    else if (rec.code == tiqt_pkg::CTRL_INTERRUPT)
                    begin
                        r.interrupt_request = !raw_mode_q && fg_present_q;
                        r.out_char = tiqt_pkg::CHAR_ETX;
                    end
                    else if (rec.code >= tiqt_pkg::CTRL_NAV_FIRST &&
                             rec.code <= tiqt_pkg::CTRL_NAV_LAST)
                    begin
                        nav = 4'(rec.code - tiqt_pkg::CTRL_NAV_FIRST);
                        esc_bytes[0] = tiqt_pkg::CHAR_ESC;
                        esc_bytes[1] = "[";
                        esc_bytes[2] = NAV_FINAL[nav];
                        esc_bytes[3] = (nav >= tiqt_pkg::NAV_LONG_FIRST) ? "~" : 8'h00;
                        esc_len = (nav >= tiqt_pkg::NAV_LONG_FIRST) ? 3'd4 : 3'd3;
                        esc_pos = '0;
                        r.out_char = next_escape_byte();
                    end
                    else
                    begin
                        // skip scroll, unsupported and out-of-range codes
                        done = 1'b0;
                        r.read_status = tiqt_pkg::RD_NONE;
                        if (rec.code == tiqt_pkg::CTRL_SCROLL_UP && !raw_mode_q)
                            r.scroll_up_request = 1'b1;
                        if (rec.code == tiqt_pkg::CTRL_SCROLL_DOWN && !raw_mode_q)
                            r.scroll_down_request = 1'b1;
                    end
                end
            end
        end
        r.drop_count = drops;
        expected_replies.push_back(r);
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // driver: present one item at a time from key_queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                translate_key(held_key);
                keys_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (key_queue.size() > 0 && !sender_paused &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    held_key = key_queue.pop_front();
                    in_valid     <= 1'b1;
                    mode         <= held_key.mode;
                    is_control   <= held_key.is_control;
                    data_byte    <= held_key.data_byte;
                    control_code <= held_key.control_code;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_replies.size() == 0)
                    report_failure("result arrived with nothing expected");
                else
                begin
                    want_reply = expected_replies.pop_front();
                    check_field("push_accepted", 32'(push_accepted),
                                32'(want_reply.push_accepted));
                    check_field("read_status", 32'(read_status),
                                32'(want_reply.read_status));
                    check_field("out_char", 32'(out_char), 32'(want_reply.out_char));
                    check_field("interrupt_request", 32'(interrupt_request),
                                32'(want_reply.interrupt_request));
                    check_field("scroll_up_request", 32'(scroll_up_request),
                                32'(want_reply.scroll_up_request));
                    check_field("scroll_down_request", 32'(scroll_down_request),
                                32'(want_reply.scroll_down_request));
                    check_field("drop_count", drop_count, want_reply.drop_count);
                end
            end
            if (stall_left == 0 && stall_request > 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles: %0d items waiting, %0d results outstanding",
                     cycle_count, key_queue.size(), expected_replies.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_key(input key_t k);
        key_queue.push_back(k);
        queued_keys++;
    endtask

    function automatic key_t random_read();
        key_t k;
        k.mode         = tiqt_pkg::MODE_READ;
        k.is_control   = 1'($urandom_range(1));
        k.data_byte    = 8'($urandom_range(255));
        k.control_code = 5'($urandom_range(31));
        return k;
    endfunction

    function automatic key_t random_push();
        key_t k;
        k = random_read();
        k.is_control = ($urandom_range(3) != 0);
        if ($urandom_range(4) != 0)
            k.control_code = 5'($urandom_range(17));
        if ($urandom_range(1) == 1)
        begin
            k.mode = tiqt_pkg::MODE_PUSH_RAW;
            // favor control bytes so classification sees them often
            if ($urandom_range(2) == 0)
                k.data_byte = 8'($urandom_range(31));
            else if ($urandom_range(7) == 0)
                k.data_byte = tiqt_pkg::CHAR_DEL;
        end
        else
        begin
            k.mode = tiqt_pkg::MODE_PUSH_REC;
        end
        return k;
    endfunction

    task automatic queue_round();
        int   pick;
        int   n;
        key_t k;
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            n = $urandom_range(1, 12);
            repeat (n) add_key(random_push());
            repeat (n + $urandom_range(n) + 1) add_key(random_read());
        end
        else if (pick < 9)
        begin
            repeat ($urandom_range(4, 16))
                add_key(($urandom_range(1) == 1) ? random_push() : random_read());
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                k = random_read();
                if ($urandom_range(1) == 1)
                    k.mode = MODE_NOP;
                add_key(k);
            end
        end
    endtask

    task automatic hold_sender_until_empty();
        sender_paused = 1'b1;
        while (in_valid || expected_replies.size() > 0)
            @(posedge clk);
        sender_paused = 1'b0;
    endtask

    task automatic drain_all();
        while (key_queue.size() > 0 || in_valid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        int start;
        start = queued_keys;
        while (queued_keys - start < n)
            queue_round();
        while (key_queue.size() > n / 2)
            @(posedge clk);
        hold_sender_until_empty();
    endtask

    task automatic write_reg(input logic idx, input logic val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == tiqt_pkg::CFG_RAW_MODE)
        begin
            raw_mode_q = val;
            esc_len = '0;
            esc_pos = '0;
        end
        else
        begin
            fg_present_q = val;
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: classified bytes, nav expansion, skipped controls, no-op
        write_reg(tiqt_pkg::CFG_FOREGROUND, 1'b1);
        foreach (DIRECTED_BYTES[i])
            add_key(key_t'{tiqt_pkg::MODE_PUSH_RAW, 1'b0, DIRECTED_BYTES[i],
                           tiqt_pkg::CTRL_NONE});
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b1, 8'h00, tiqt_pkg::CTRL_NONE});
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b1, 8'h55, tiqt_pkg::CTRL_NAV_LAST});
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b1, 8'hff, tiqt_pkg::CTRL_SCROLL_UP});
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b1, 8'h00, tiqt_pkg::CTRL_SCROLL_DOWN});
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b1, 8'h41, tiqt_pkg::CTRL_UNSUPPORTED});
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b0, 8'h80, tiqt_pkg::CTRL_EOF});
        add_key(key_t'{MODE_NOP, 1'b1, 8'hff, 5'h1f});
        repeat (14) add_key(random_read());
        // leave an escape sequence pending across the next mode write
        add_key(key_t'{tiqt_pkg::MODE_PUSH_REC, 1'b1, 8'h00, tiqt_pkg::CTRL_NAV_FIRST});
        add_key(random_read());
        drain_all();

        send_idle_pct = 35;
        recv_idle_pct = 52;
        write_reg(tiqt_pkg::CFG_RAW_MODE, 1'b0);
        write_reg(tiqt_pkg::CFG_FOREGROUND, 1'b0);
        run_phase(300);
        drain_all();

        send_idle_pct = 52;
        recv_idle_pct = 35;
        write_reg(tiqt_pkg::CFG_RAW_MODE, 1'b1);
        write_reg(tiqt_pkg::CFG_FOREGROUND, 1'b1);
        // hold the output long enough for the input to back up
        stall_request = LONG_STALL;
        run_phase(300);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(tiqt_pkg::CFG_FOREGROUND, 1'b0);
        // overflow the ring, then read it back
        repeat (DEPTH + 6) add_key(random_push());
        repeat (DEPTH + 6) add_key(random_read());
        drain_all();

        write_reg(tiqt_pkg::CFG_RAW_MODE, 1'b0);
        write_reg(tiqt_pkg::CFG_FOREGROUND, 1'b1);
        run_phase(250);
        drain_all();

        $display("Checked %0d results for %0d items; %0d pushes dropped,",
                 results_seen, keys_sent, drops);
        $display("%0d escape bytes, %0d eof reads; canonical and raw modes, %s",
                 escape_bytes, eof_reads, "ring overflow and a long output stall");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
